// ===== hdl/e2a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2a_pkg
// Shared types, constants and coefficient helper for the approximate
// base-two exponential unit.
// ----------------------------------------------------------------------------
package e2a_pkg;

  localparam int unsigned FIX_POS = 56;
  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_MAX = 8'hFF;
  localparam logic [7:0] EXP_SAT = 8'd135;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] POS_ZERO = 32'h0000_0000;
  localparam int unsigned MANT_BITS = 23;

  localparam logic [63:0] DEC_SCALE = 64'd1000000000000000;
  localparam logic [63:0] COEF0_DEC = 64'd1001724758577790;
  localparam logic [63:0] COEF1_DEC = 64'd657636286949233;
  localparam logic [63:0] COEF2_DEC = 64'd337189437317397;

  typedef struct packed {
    logic               special;
    logic [31:0]        special_bits;
    logic signed [9:0]  k;
  } e2a_side_t;

  // Scales a decimal coefficient (units of 1e-15, below 2.0) to fixed point
  // with the given number of fraction bits, rounding to nearest, ties up.
  function automatic logic [63:0] coef_fixed(input logic [63:0] dec,
                                             input int unsigned frac_bits);
    logic [63:0] q;
    logic [63:0] r;
    q = (dec >= DEC_SCALE) ? 64'd1 : 64'd0;
    r = (dec >= DEC_SCALE) ? (dec - DEC_SCALE) : dec;
    for (int i = 0; i < 32; i++) begin
      if (i < frac_bits + 1) begin
        r = r << 1;
        q = q << 1;
        if (r >= DEC_SCALE) begin
          r = r - DEC_SCALE;
          q = q | 64'd1;
        end
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

endpackage

// ===== hdl/e2a_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2a_reduce
// Two-stage range reduction: aligns |x| to fixed point, then forms the
// integer part k = floor(x) and the fraction f, and flags special operands.
// ----------------------------------------------------------------------------
module e2a_reduce import e2a_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          x_bits_i,
  output logic                 valid_o,
  output logic [FRAC_BITS-1:0] f_o,
  output e2a_side_t            side_o
);

  logic        neg;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [23:0] m;
  logic [7:0]  eeff;
  logic [5:0]  lsh;
  logic [6:0]  rsh;
  logic [63:0] m_ext;
  logic [63:0] a1_d;
  logic        sticky1_d;
  logic        special1_d;
  logic [31:0] spbits1_d;

  logic        v1_q;
  logic [63:0] a1_q;
  logic        sticky1_q;
  logic        neg1_q;
  logic        special1_q;
  logic [31:0] spbits1_q;

  logic [55:0]          fr;
  logic [7:0]           kmag;
  logic [56:0]          fneg;
  logic [FRAC_BITS-1:0] f2_d;
  e2a_side_t            side2_d;

  logic                 v2_q;
  logic [FRAC_BITS-1:0] f2_q;
  e2a_side_t            side2_q;

  always_comb begin
    neg   = x_bits_i[31];
    ex    = x_bits_i[30:23];
    man   = x_bits_i[22:0];
    m     = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
    eeff  = (ex == 8'd0) ? 8'd1 : ex;
    m_ext = {40'd0, m};
    lsh   = 6'd0;
    rsh   = 7'd0;
    a1_d      = 64'd0;
    sticky1_d = 1'b0;
    if (eeff >= 8'd94) begin
      lsh  = 6'(eeff - 8'd94);
      a1_d = m_ext << lsh;
    end else begin
      rsh = 7'(8'd94 - eeff);
      if (rsh >= 7'd64) begin
        sticky1_d = (m != 24'd0);
      end else begin
        a1_d      = m_ext >> rsh[5:0];
        sticky1_d = |(m_ext & ((64'd1 << rsh[5:0]) - 64'd1));
      end
    end
    special1_d = 1'b0;
    spbits1_d  = POS_ZERO;
    if (ex == EXP_MAX && man != 23'd0) begin
      special1_d = 1'b1;
      spbits1_d  = x_bits_i;
    end else if (ex >= EXP_SAT) begin
      special1_d = 1'b1;
      spbits1_d  = neg ? POS_ZERO : POS_INF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q       <= a1_d;
    sticky1_q  <= sticky1_d;
    neg1_q     <= neg;
    special1_q <= special1_d;
    spbits1_q  <= spbits1_d;
  end

  always_comb begin
    fr   = a1_q[FIX_POS-1:0];
    kmag = a1_q[63:FIX_POS];
    fneg = (57'd1 << FIX_POS) - {1'b0, fr} - {56'd0, sticky1_q};
    side2_d.special      = special1_q;
    side2_d.special_bits = spbits1_q;
    if (!neg1_q) begin
      side2_d.k = {2'b00, kmag};
      f2_d      = fr[FIX_POS-1 -: FRAC_BITS];
    end else if (fr == 56'd0 && !sticky1_q) begin
      side2_d.k = 10'd0 - {2'b00, kmag};
      f2_d      = '0;
    end else begin
      side2_d.k = 10'h3FF - {2'b00, kmag};
      f2_d      = fneg[FIX_POS-1 -: FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    f2_q    <= f2_d;
    side2_q <= side2_d;
  end

  assign valid_o = v2_q;
  assign f_o     = f2_q;
  assign side_o  = side2_q;

endmodule

// ===== hdl/e2a_horner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2a_horner
// First Horner steps of the quadratic: f*C2, then C1 + (f*C2 >> FRAC_BITS),
// then f times that partial sum, each in its own register stage.
// ----------------------------------------------------------------------------
module e2a_horner import e2a_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [FRAC_BITS-1:0]     f_i,
  input  e2a_side_t                side_i,
  output logic                     valid_o,
  output logic [2*FRAC_BITS+1:0]   prod_o,
  output e2a_side_t                side_o
);

  localparam logic [63:0] C1_FULL = coef_fixed(COEF1_DEC, FRAC_BITS);
  localparam logic [63:0] C2_FULL = coef_fixed(COEF2_DEC, FRAC_BITS);
  localparam logic [FRAC_BITS+1:0] C1 = C1_FULL[FRAC_BITS+1:0];
  localparam logic [FRAC_BITS+1:0] C2 = C2_FULL[FRAC_BITS+1:0];

  logic [2*FRAC_BITS+1:0] p1_d;
  logic [FRAC_BITS+1:0]   acc1_d;
  logic [2*FRAC_BITS+1:0] p2_d;

  logic                   v3_q;
  logic [FRAC_BITS-1:0]   f3_q;
  e2a_side_t              side3_q;
  logic [2*FRAC_BITS+1:0] p1_q;

  logic                   v4_q;
  logic [FRAC_BITS-1:0]   f4_q;
  e2a_side_t              side4_q;
  logic [FRAC_BITS+1:0]   acc1_q;

  logic                   v5_q;
  e2a_side_t              side5_q;
  logic [2*FRAC_BITS+1:0] p2_q;

  assign p1_d   = {{(FRAC_BITS+2){1'b0}}, f_i} * {{FRAC_BITS{1'b0}}, C2};
  assign acc1_d = C1 + p1_q[2*FRAC_BITS+1:FRAC_BITS];
  assign p2_d   = {{(FRAC_BITS+2){1'b0}}, f4_q} * {{FRAC_BITS{1'b0}}, acc1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f3_q    <= f_i;
    side3_q <= side_i;
    p1_q    <= p1_d;
    f4_q    <= f3_q;
    side4_q <= side3_q;
    acc1_q  <= acc1_d;
    side5_q <= side4_q;
    p2_q    <= p2_d;
  end

  assign valid_o = v5_q;
  assign prod_o  = p2_q;
  assign side_o  = side5_q;

endmodule

// ===== hdl/e2a_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2a_pack
// Final Horner add with C0, clamp below 2.0, exponent adjust by k with
// saturation, and packing into the registered single-precision result.
// ----------------------------------------------------------------------------
module e2a_pack import e2a_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [2*FRAC_BITS+1:0] prod_i,
  input  e2a_side_t              side_i,
  output logic                   done_o,
  output logic [31:0]            result_bits_o
);

  localparam logic [63:0] C0_FULL = coef_fixed(COEF0_DEC, FRAC_BITS);
  localparam logic [FRAC_BITS+1:0] C0 = C0_FULL[FRAC_BITS+1:0];
  localparam logic [FRAC_BITS+1:0] TWO = {2'b10, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS+1:0]  acc_sum;
  logic [FRAC_BITS+1:0]  acc;
  logic [FRAC_BITS-1:0]  frac;
  logic [MANT_BITS-1:0]  mant;
  logic signed [10:0]    biased;
  logic [31:0]           res_d;

  logic                  done_q;
  logic [31:0]           res_q;

  assign acc_sum = C0 + prod_i[2*FRAC_BITS+1:FRAC_BITS];
  assign acc     = (acc_sum >= TWO) ? (TWO - 1'b1) : acc_sum;
  assign frac    = acc[FRAC_BITS-1:0];

  if (FRAC_BITS >= MANT_BITS) begin : g_trunc
    assign mant = frac[FRAC_BITS-1 -: MANT_BITS];
  end else begin : g_pad
    assign mant = {frac, {(MANT_BITS-FRAC_BITS){1'b0}}};
  end

  assign biased = {side_i.k[9], side_i.k} + 11'sd127;

  always_comb begin
    if (side_i.special) begin
      res_d = side_i.special_bits;
    end else if (biased >= 11'sd255) begin
      res_d = POS_INF;
    end else if (biased <= 11'sd0) begin
      res_d = POS_ZERO;
    end else begin
      res_d = {1'b0, biased[7:0], mant};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o        = done_q;
  assign result_bits_o = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !side_i.special |-> acc[FRAC_BITS] && !acc[FRAC_BITS+1])
    else $error("e2a_pack: polynomial value left [1,2)");

endmodule

// ===== hdl/fast_exp2_approx_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_exp2_approx_unit
// Approximate 2^x on single-precision bit patterns by range reduction and a
// quadratic polynomial in fixed point.
// Each accepted item's result appears on the result ports with done_o high.
// Throughput: one item per cycle in a six-stage pipeline; busy stays low.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module fast_exp2_approx_unit import e2a_pkg::*; #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits_i,
  output logic        done_o,
  output logic [31:0] result_bits_o
);

  logic                   red_valid;
  logic [FRAC_BITS-1:0]   red_f;
  e2a_side_t              red_side;
  logic                   hor_valid;
  logic [2*FRAC_BITS+1:0] hor_prod;
  e2a_side_t              hor_side;

  assign busy = 1'b0;

  e2a_reduce #(
    .FRAC_BITS(FRAC_BITS)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .x_bits_i(x_bits_i),
    .valid_o (red_valid),
    .f_o     (red_f),
    .side_o  (red_side)
  );

  e2a_horner #(
    .FRAC_BITS(FRAC_BITS)
  ) u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(red_valid),
    .f_i    (red_f),
    .side_i (red_side),
    .valid_o(hor_valid),
    .prod_o (hor_prod),
    .side_o (hor_side)
  );

  e2a_pack #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (hor_valid),
    .prod_i       (hor_prod),
    .side_i       (hor_side),
    .done_o       (done_o),
    .result_bits_o(result_bits_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("fast_exp2_approx_unit: accepted item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6))
    else $error("fast_exp2_approx_unit: result without an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_bits_o[31] |->
      result_bits_o[30:23] == EXP_MAX && result_bits_o[22:0] != 23'd0)
    else $error("fast_exp2_approx_unit: negative result that is not a NaN");

endmodule

// ===== tb/sv/fast_exp2_approx_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_exp2_approx_unit_tb
// Self-checking bench for the approximate base-two exponential unit. A
// directed table covers NaN, infinities, saturation, signed zeros,
// subnormals and exponent limits, then random operands follow under several
// start pacing phases. Results are compared with a table value where given,
// else a local bit-exact predictor of the range reduction and quadratic.
// ----------------------------------------------------------------------------
module fast_exp2_approx_unit_tb;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned FIX_PT = 56;
  localparam logic [63:0] DEC_ONE = 64'd1000000000000000;
  localparam logic [31:0] INF_BITS = 32'h7F80_0000;
  localparam logic [31:0] ZERO_BITS = 32'h0000_0000;
  localparam int unsigned NUM_DIRECTED = 25;
  localparam int unsigned ITEMS_PER_PHASE = 112;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] x;
    logic        known;
    logic [31:0] res;
  } exp2_row_t;

  function automatic logic [63:0] decimal_to_q(input logic [63:0] dec);
    logic [63:0] q;
    logic [63:0] r;
    q = dec / DEC_ONE;
    r = dec % DEC_ONE;
    for (int i = 0; i < FRAC_BITS + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DEC_ONE) begin
        r = r - DEC_ONE;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  localparam logic [63:0] POLY_C0 = decimal_to_q(64'd1001724758577790);
  localparam logic [63:0] POLY_C1 = decimal_to_q(64'd657636286949233);
  localparam logic [63:0] POLY_C2 = decimal_to_q(64'd337189437317397);

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] x_bits_i;
  logic        done_o;
  logic [31:0] result_bits_o;

  logic        row_known;
  logic [31:0] row_res;

  logic [31:0] pending_exp2_q[$];
  int unsigned error_cnt;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned inf_seen;
  int unsigned zero_seen;
  int unsigned nan_seen;
  int unsigned idle_cycles;

  exp2_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h7FC0_0001, 1'b1, 32'h7FC0_0001},
    '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h7F80_0001, 1'b1, 32'h7F80_0001},
    '{32'h7F80_0000, 1'b1, INF_BITS},
    '{32'hFF80_0000, 1'b1, ZERO_BITS},
    '{32'h4380_0000, 1'b1, INF_BITS},
    '{32'hC380_0000, 1'b1, ZERO_BITS},
    '{32'h7F7F_FFFF, 1'b1, INF_BITS},
    '{32'hFF7F_FFFF, 1'b1, ZERO_BITS},
    '{32'h437F_FFFF, 1'b1, INF_BITS},
    '{32'hC37F_FFFF, 1'b1, ZERO_BITS},
    '{32'h4300_0000, 1'b1, INF_BITS},
    '{32'hC2FE_0000, 1'b1, ZERO_BITS},
    '{32'hC2FD_0000, 1'b1, ZERO_BITS},
    '{32'h0000_0000, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 32'h0},
    '{32'h8000_0001, 1'b0, 32'h0},
    '{32'h007F_FFFF, 1'b0, 32'h0},
    '{32'h3F80_0000, 1'b0, 32'h0},
    '{32'hBF00_0000, 1'b0, 32'h0},
    '{32'hBF7F_FFFF, 1'b0, 32'h0},
    '{32'h42FE_0000, 1'b0, 32'h0},
    '{32'hC2FC_0000, 1'b0, 32'h0},
    '{32'hC049_0FDB, 1'b0, 32'h0}
  };

  fast_exp2_approx_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .x_bits_i(x_bits_i),
    .done_o(done_o),
    .result_bits_o(result_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] exp2_approx_bits(input logic [31:0] x);
    logic        sign;
    logic [7:0]  expo;
    logic [22:0] man;
    logic [63:0] mag;
    logic [63:0] low;
    logic [63:0] unit;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] mant;
    logic        sticky;
    int          sh;
    int          k;
    int          biased;
    sign = x[31];
    expo = x[30:23];
    man = x[22:0];
    if (expo == 8'hFF && man != 23'd0) return x;
    if (expo >= 8'd135) return sign ? ZERO_BITS : INF_BITS;
    mag = (expo == 8'd0) ? {41'd0, man} : {40'd0, 1'b1, man};
    sh = ((expo == 8'd0) ? 1 : int'(expo)) - 150 + FIX_PT;
    sticky = 1'b0;
    if (sh >= 0) begin
      mag = mag << sh;
    end else if (sh <= -64) begin
      sticky = (mag != 64'd0);
      mag = 64'd0;
    end else begin
      sticky = (mag & ((64'd1 << (-sh)) - 64'd1)) != 64'd0;
      mag = mag >> (-sh);
    end
    unit = 64'd1 << FIX_PT;
    low = mag & (unit - 64'd1);
    k = int'(mag >> FIX_PT);
    if (!sign) begin
      f = low >> (FIX_PT - FRAC_BITS);
    end else if (low == 64'd0 && !sticky) begin
      k = -k;
      f = 64'd0;
    end else begin
      k = -k - 1;
      f = (unit - low - 64'(sticky)) >> (FIX_PT - FRAC_BITS);
    end
    acc = POLY_C2;
    acc = POLY_C1 + ((f * acc) >> FRAC_BITS);
    acc = POLY_C0 + ((f * acc) >> FRAC_BITS);
    if (acc >= (64'd2 << FRAC_BITS)) acc = (64'd2 << FRAC_BITS) - 64'd1;
    biased = k + 127;
    if (biased >= 255) return INF_BITS;
    if (biased <= 0) return ZERO_BITS;
    acc = acc - (64'd1 << FRAC_BITS);
    mant = (FRAC_BITS >= 23) ? (acc >> (FRAC_BITS - 23)) : (acc << (23 - FRAC_BITS));
    return {1'b0, 8'(biased), mant[22:0]};
  endfunction

  function automatic logic [31:0] random_operand();
    int unsigned sel;
    logic        s;
    logic [22:0] m;
    sel = $urandom_range(99, 0);
    s = 1'($urandom_range(1, 0));
    m = 23'($urandom);
    if (sel < 30) return $urandom;
    if (sel < 75) return {s, 8'($urandom_range(134, 100)), m};
    if (sel < 85) return {s, 8'($urandom_range(135, 126)), m & {6'h3F, 17'h0}};
    if (sel < 92) return {s, 8'hFF, ($urandom_range(3, 0) == 0) ? 23'd0 : m};
    return {s, 8'($urandom_range(5, 0)), m};
  endfunction

  task automatic send_item(input logic [31:0] x, input logic known, input logic [31:0] res,
                           input int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    x_bits_i <= x;
    row_known <= known;
    row_res <= res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (start && !busy) begin
        pending_exp2_q.push_back(row_known ? row_res : exp2_approx_bits(x_bits_i));
      end
      if (done_o) begin
        results_checked++;
        if (result_bits_o == INF_BITS) inf_seen++;
        if (result_bits_o == ZERO_BITS) zero_seen++;
        if (result_bits_o[30:23] == 8'hFF && result_bits_o[22:0] != 23'd0) nan_seen++;
        if (pending_exp2_q.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10) begin
            $display("[%0t] unexpected result %h", $realtime, result_bits_o);
          end
        end else begin
          want = pending_exp2_q.pop_front();
          if (result_bits_o !== want) begin
            error_cnt++;
            if (error_cnt <= 10) begin
              $display("[%0t] result_bits mismatch: expected %h, got %h",
                       $realtime, want, result_bits_o);
            end
          end
        end
      end
      if ((start && !busy) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[%0t] watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
          $display("fast_exp2_approx_unit_tb: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned pacing [4];
    pacing = '{0, 86, 0, 36};
    error_cnt = 0;
    items_sent = 0;
    results_checked = 0;
    inf_seen = 0;
    zero_seen = 0;
    nan_seen = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    x_bits_i = 32'd0;
    row_known = 1'b0;
    row_res = 32'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(directed_rows[i].x, directed_rows[i].known, directed_rows[i].res, 0);
    end
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(random_operand(), 1'b0, 32'd0, pacing[p]);
      end
    end
    start <= 1'b0;

    while (pending_exp2_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d operands (%0d table rows, 4 pacing phases); checked %0d results.",
             items_sent, NUM_DIRECTED, results_checked);
    $display("Results seen: %0d infinity, %0d zero, %0d NaN; %0d mismatches.",
             inf_seen, zero_seen, nan_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("fast_exp2_approx_unit_tb: PASS");
    end else begin
      $display("fast_exp2_approx_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/e2a_pkg.sv
hdl/e2a_reduce.sv
hdl/e2a_horner.sv
hdl/e2a_pack.sv
hdl/fast_exp2_approx_unit.sv
tb/sv/fast_exp2_approx_unit_tb.sv
